/* hdl/pfe_pkg.sv */
// shared types, constants and helper functions for the playfair digraph encryptor
package pfe_pkg;

    localparam int LETTER_W = 5;
    localparam int SIDE     = 5;
    localparam int ROW_W    = SIDE * LETTER_W;
    localparam int POS_W    = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;
    localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_ROW3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_ROW4 = 3'd4;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [ROW_W-1:0] t_row;
    typedef t_row [SIDE-1:0] t_square;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_pos;

    // letter pair handed from the pairing front end to the encoder
    typedef struct packed {
        t_letter p;
        t_letter q;
        logic    fin;
    } t_pair;

    // two cipher letters of one pair
    typedef struct packed {
        t_letter c1;
        t_letter c2;
        logic    fin;
    } t_result;

    typedef enum logic [1:0] {
        OUT_EMPTY,
        OUT_FIRST,
        OUT_SECOND
    } t_out_state;

    function automatic t_letter sq_cell(t_square sq, logic [POS_W-1:0] r,
                                        logic [POS_W-1:0] c);
        t_row    row_bits;
        t_letter val;
        row_bits = '0;
        val      = '0;
        for (int i = 0; i < SIDE; i++) begin
            if (r == POS_W'(i)) begin
                row_bits = sq[i];
            end
        end
        for (int j = 0; j < SIDE; j++) begin
            if (c == POS_W'(j)) begin
                val = row_bits[j*LETTER_W +: LETTER_W];
            end
        end
        return val;
    endfunction

    function automatic logic [POS_W-1:0] inc_wrap(logic [POS_W-1:0] v);
        return (v == POS_W'(SIDE - 1)) ? '0 : v + 1'b1;
    endfunction

endpackage

/* hdl/playfair_digraph_encrypt.sv */
// top level of the streaming playfair digraph encryptor
// Takes one plaintext letter item per cycle while o_ready is high and
// gives cipher letter items. A letter equal to the one before it in the
// same message becomes X; the first letter of a pair is held and gives
// nothing, the second (or a last letter padded with X) gives two cipher
// letters in consecutive items. The pair-completing letter is captured in
// the pair register, then goes through the key square lookup into the
// result register. Sustained rate is one input item per cycle for normal
// text while the output is not stalled; a message of one letter per
// message gives two results per input, so input is then held back by the
// single result register draining one letter per cycle. The user must
// write the key square through the config port only while the block is
// idle; the block does not enforce this, and the port is always ready.
module playfair_digraph_encrypt
    import pfe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // plaintext channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [LETTER_W-1:0]  i_plain_letter,
    input  logic                 i_message_end,
    // ciphertext channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [LETTER_W-1:0]  o_cipher_letter,
    output logic                 o_pair_second,
    output logic                 o_final_output,
    // key square write port
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ROW_W-1:0]     i_cfg_data
);

    // key square rows, column c in bits 5c+4:5c
    t_square r_square;

    // pair register handshake between the front end and the result stage
    logic    pair_valid;
    logic    pair_ready;
    t_pair   pair;
    t_result result;

    assign o_cfg_ready = 1'b1;

    // config writes; indexes past the last row are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SQUARE_ROW0: r_square[0] <= i_cfg_data;
                CFG_SQUARE_ROW1: r_square[1] <= i_cfg_data;
                CFG_SQUARE_ROW2: r_square[2] <= i_cfg_data;
                CFG_SQUARE_ROW3: r_square[3] <= i_cfg_data;
                CFG_SQUARE_ROW4: r_square[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // doubled letter replacement and pairing
    pfe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_plain_letter (i_plain_letter),
        .i_message_end  (i_message_end),
        .o_pair_valid   (pair_valid),
        .i_pair_ready   (pair_ready),
        .o_pair         (pair)
    );

    // square lookup and cipher rules
    pfe_encode u_encode (
        .i_square (r_square),
        .i_pair   (pair),
        .o_result (result)
    );

    // result register, two letters per pair
    pfe_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pair_valid    (pair_valid),
        .o_pair_ready    (pair_ready),
        .i_result        (result),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_cipher_letter (o_cipher_letter),
        .o_pair_second   (o_pair_second),
        .o_final_output  (o_final_output)
    );

endmodule

/* hdl/pfe_front.sv */
// letter replacement, pairing state and the pair register
module pfe_front
    import pfe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_letter i_plain_letter,
    input  logic    i_message_end,
    output logic    o_pair_valid,
    input  logic    i_pair_ready,
    output t_pair   o_pair
);

    logic    r_prev_valid, n_prev_valid;
    t_letter r_prev_letter, n_prev_letter;
    logic    r_pend_valid, n_pend_valid;
    t_letter r_pend_letter, n_pend_letter;
    logic    r_pair_valid, n_pair_valid;
    t_pair   r_pair, n_pair;

    t_letter letter;
    logic    accept;
    logic    pair_load;

    always_comb begin
        letter = (r_prev_valid && i_plain_letter == r_prev_letter) ? LETTER_X
                                                                   : i_plain_letter;
        o_ready   = !r_pair_valid || i_pair_ready;
        accept    = i_valid && o_ready;
        pair_load = accept && (r_pend_valid || i_message_end);

        n_prev_valid  = r_prev_valid;
        n_prev_letter = r_prev_letter;
        n_pend_valid  = r_pend_valid;
        n_pend_letter = r_pend_letter;
        n_pair        = r_pair;
        n_pair_valid  = r_pair_valid && !i_pair_ready;

        if (accept) begin
            n_prev_letter = letter;
            n_prev_valid  = !i_message_end;
            if (r_pend_valid) begin
                n_pend_valid = 1'b0;
                n_pair       = '{p: r_pend_letter, q: letter, fin: i_message_end};
            end else if (i_message_end) begin
                n_pair = '{p: letter, q: LETTER_X, fin: 1'b1};
            end else begin
                n_pend_letter = letter;
                n_pend_valid  = 1'b1;
            end
        end
        if (pair_load) begin
            n_pair_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid  <= 1'b0;
            r_prev_letter <= '0;
            r_pend_valid  <= 1'b0;
            r_pair_valid  <= 1'b0;
        end else begin
            r_prev_valid  <= n_prev_valid;
            r_prev_letter <= n_prev_letter;
            r_pend_valid  <= n_pend_valid;
            r_pair_valid  <= n_pair_valid;
        end
        r_pend_letter <= n_pend_letter;
        r_pair        <= n_pair;
    end

    assign o_pair_valid = r_pair_valid;
    assign o_pair       = r_pair;

endmodule

/* hdl/pfe_encode.sv */
// key square lookup and the playfair row, column and rectangle rules
module pfe_encode
    import pfe_pkg::*;
(
    input  t_square i_square,
    input  t_pair   i_pair,
    output t_result o_result
);

    t_pos pos_a, pos_b;

    function automatic t_pos locate(t_square sq, t_letter raw);
        t_letter key;
        t_pos    pos;
        key = (raw == LETTER_J) ? LETTER_I : raw;
        pos = '0;
        // scan backward so the first match in row-major order wins
        for (int r = SIDE - 1; r >= 0; r--) begin
            for (int c = SIDE - 1; c >= 0; c--) begin
                if (sq[r][c*LETTER_W +: LETTER_W] == key) begin
                    pos.row = POS_W'(r);
                    pos.col = POS_W'(c);
                end
            end
        end
        return pos;
    endfunction

    always_comb begin
        pos_a        = locate(i_square, i_pair.p);
        pos_b        = locate(i_square, i_pair.q);
        o_result.fin = i_pair.fin;
        if (pos_a.row == pos_b.row) begin
            o_result.c1 = sq_cell(i_square, pos_a.row, inc_wrap(pos_a.col));
            o_result.c2 = sq_cell(i_square, pos_b.row, inc_wrap(pos_b.col));
        end else if (pos_a.col == pos_b.col) begin
            o_result.c1 = sq_cell(i_square, inc_wrap(pos_a.row), pos_a.col);
            o_result.c2 = sq_cell(i_square, inc_wrap(pos_b.row), pos_b.col);
        end else begin
            o_result.c1 = sq_cell(i_square, pos_a.row, pos_b.col);
            o_result.c2 = sq_cell(i_square, pos_b.row, pos_a.col);
        end
    end

endmodule

/* hdl/pfe_out.sv */
// result register holding one encoded pair, drained one letter per item
module pfe_out
    import pfe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_pair_valid,
    output logic    o_pair_ready,
    input  t_result i_result,
    output logic    o_valid,
    input  logic    i_ready,
    output t_letter o_cipher_letter,
    output logic    o_pair_second,
    output logic    o_final_output
);

    t_out_state r_state, n_state;
    t_result    r_res, n_res;
    logic       load;

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        case (r_state)
            OUT_EMPTY:  o_pair_ready = 1'b1;
            OUT_SECOND: o_pair_ready = i_ready;
            default:    o_pair_ready = 1'b0;
        endcase
        load = i_pair_valid && o_pair_ready;
        case (r_state)
            OUT_FIRST: begin
                if (i_ready) begin
                    n_state = OUT_SECOND;
                end
            end
            OUT_SECOND: begin
                if (i_ready) begin
                    n_state = OUT_EMPTY;
                end
            end
            default: begin
                n_state = OUT_EMPTY;
            end
        endcase
        if (load) begin
            n_state = OUT_FIRST;
            n_res   = i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= OUT_EMPTY;
        end else begin
            r_state <= n_state;
        end
        r_res <= n_res;
    end

    assign o_valid         = (r_state != OUT_EMPTY);
    assign o_pair_second   = (r_state == OUT_SECOND);
    assign o_cipher_letter = (r_state == OUT_SECOND) ? r_res.c2 : r_res.c1;
    assign o_final_output  = (r_state == OUT_SECOND) && r_res.fin;

endmodule

/* hdl/pfe_checker.sv */
// port level checks for the playfair digraph encryptor, bound to the top level
module pfe_checker
    import pfe_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_ready,
    input logic [LETTER_W-1:0] o_cipher_letter,
    input logic                o_pair_second,
    input logic                o_final_output
);

    // nothing shows right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    // a first cipher letter is always followed by its second once taken
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_pair_second && i_ready) |=> (o_valid && o_pair_second))
        else $error("second letter of pair missing");

    // the second letter, once taken, never shows again
    a_second_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pair_second && i_ready) |=> !(o_valid && o_pair_second))
        else $error("second letter repeated");

    // message end only on a second letter
    a_final_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_final_output) |-> o_pair_second)
        else $error("final flag on first letter of pair");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_cipher_letter)))
        else $error("stalled result changed");

endmodule

bind playfair_digraph_encrypt pfe_checker u_pfe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_cipher_letter (o_cipher_letter),
    .o_pair_second   (o_pair_second),
    .o_final_output  (o_final_output)
);

/* dv/cipher_tracker_pkg.sv */
`timescale 1ns / 1ps
// expected cipher letter tracker for the playfair encryptor testbench
package cipher_tracker_pkg;
    import pfe_pkg::*;

    typedef struct packed {
        t_letter letter;
        logic    second;
        logic    fin;
    } t_cipher_item;

    class cipher_tracker;
        t_square      square;
        t_letter      prev_letter;
        logic         prev_valid;
        t_letter      held_letter;
        logic         held_valid;
        t_cipher_item cipher_due[$];
        int           errors;

        function new();
            square      = '0;
            prev_letter = '0;
            prev_valid  = 1'b0;
            held_letter = '0;
            held_valid  = 1'b0;
            errors      = 0;
        endfunction

        function void write_row(logic [CFG_IDX_W-1:0] index, t_row data);
            case (index)
                CFG_SQUARE_ROW0: square[0] = data;
                CFG_SQUARE_ROW1: square[1] = data;
                CFG_SQUARE_ROW2: square[2] = data;
                CFG_SQUARE_ROW3: square[3] = data;
                CFG_SQUARE_ROW4: square[4] = data;
                default: ;
            endcase
        endfunction

        function t_letter square_at(int r, int c);
            return square[r][c*LETTER_W +: LETTER_W];
        endfunction

        // first match in row-major order, (0,0) when absent
        function void find_letter(t_letter letter, output int r, output int c);
            t_letter key;
            int      i;
            key = (letter == LETTER_J) ? LETTER_I : letter;
            r = 0;
            c = 0;
            for (i = SIDE*SIDE-1; i >= 0; i--) begin
                if (square_at(i / SIDE, i % SIDE) == key) begin
                    r = i / SIDE;
                    c = i % SIDE;
                end
            end
        endfunction

        function void encrypt_pair(t_letter p, t_letter q, logic fin);
            int      ar, ac, br, bc;
            t_letter c1, c2;
            find_letter(p, ar, ac);
            find_letter(q, br, bc);
            if (ar == br) begin
                c1 = square_at(ar, (ac + 1) % SIDE);
                c2 = square_at(br, (bc + 1) % SIDE);
            end else if (ac == bc) begin
                c1 = square_at((ar + 1) % SIDE, ac);
                c2 = square_at((br + 1) % SIDE, bc);
            end else begin
                c1 = square_at(ar, bc);
                c2 = square_at(br, ac);
            end
            cipher_due.push_back('{c1, 1'b0, 1'b0});
            cipher_due.push_back('{c2, 1'b1, fin});
        endfunction

        function void take_letter(t_letter plain, logic last);
            t_letter letter;
            letter = plain;
            if (prev_valid && letter == prev_letter) begin
                letter = LETTER_X;
            end
            prev_letter = letter;
            prev_valid  = !last;
            if (held_valid) begin
                held_valid = 1'b0;
                encrypt_pair(held_letter, letter, last);
                held_letter = '0;
            end else if (last) begin
                encrypt_pair(letter, LETTER_X, 1'b1);
            end else begin
                held_letter = letter;
                held_valid  = 1'b1;
            end
        endfunction

        function void check_cipher(t_letter letter, logic second, logic fin);
            t_cipher_item want;
            if (cipher_due.size() == 0) begin
                $error("cipher letter %0d with nothing expected", letter);
                errors++;
                return;
            end
            want = cipher_due.pop_front();
            if (want.letter !== letter) begin
                $error("cipher_letter: expected %0d, got %0d", want.letter, letter);
                errors++;
            end
            if (want.second !== second) begin
                $error("pair_second: expected %0d, got %0d", want.second, second);
                errors++;
            end
            if (want.fin !== fin) begin
                $error("final_output: expected %0d, got %0d", want.fin, fin);
                errors++;
            end
        endfunction

        function int outstanding();
            return cipher_due.size();
        endfunction
    endclass

endpackage

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// testbench top for the playfair digraph encryptor
module tb_top;
    import pfe_pkg::*;
    import cipher_tracker_pkg::*;

    localparam int IDLE_LIMIT    = 2000; // cycles with no handshake at all
    localparam int SETTLE_CYCLES = 6;    // extra cycles waited after all expected items are out
    localparam int PHASES        = 8;
    localparam int PHASE_LETTERS = 66;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_valid         = 1'b0;
    logic                 o_ready;
    logic [LETTER_W-1:0]  i_plain_letter  = '0;
    logic                 i_message_end   = 1'b0;
    logic                 o_valid;
    logic                 i_ready         = 1'b0;
    logic [LETTER_W-1:0]  o_cipher_letter;
    logic                 o_pair_second;
    logic                 o_final_output;
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [ROW_W-1:0]     i_cfg_data      = '0;

    t_idle_mode    idle_mode    = IDLE_NONE;
    cipher_tracker tracker;
    int            letters_sent = 0;
    int            quiet_cycles = 0;

    playfair_digraph_encrypt i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_plain_letter  (i_plain_letter),
        .i_message_end   (i_message_end),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_cipher_letter (o_cipher_letter),
        .o_pair_second   (o_pair_second),
        .o_final_output  (o_final_output),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver side back-pressure, depends on the current idling profile
    always @(posedge i_clk) begin
        case (idle_mode)
            IDLE_RECEIVER: i_ready <= ($urandom_range(99) >= 50);
            IDLE_BOTH:     i_ready <= ($urandom_range(99) >= 9);
            default:       i_ready <= 1'b1;
        endcase
    end

    // all handshakes are observed here at the clock edge, so the tracker
    // sees config writes, letters and cipher items in edge order
    always @(posedge i_clk) begin : monitor
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                tracker.write_row(i_cfg_index, i_cfg_data);
                moved = 1'b1;
            end
            if (i_valid && o_ready) begin
                tracker.take_letter(i_plain_letter, i_message_end);
                moved = 1'b1;
            end
            if (o_valid && i_ready) begin
                tracker.check_cipher(o_cipher_letter, o_pair_second, o_final_output);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // one row write; valid stays up across back-to-back rows
    task automatic send_row(logic [CFG_IDX_W-1:0] index, t_row data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic write_square(t_square sq);
        send_row(CFG_SQUARE_ROW0, sq[0]);
        send_row(CFG_SQUARE_ROW1, sq[1]);
        send_row(CFG_SQUARE_ROW2, sq[2]);
        send_row(CFG_SQUARE_ROW3, sq[3]);
        send_row(CFG_SQUARE_ROW4, sq[4]);
        i_cfg_valid <= 1'b0;
    endtask

    // one letter item, with random sender gaps ahead of it
    task automatic send_letter(t_letter letter, logic last);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER) ? 50 : (idle_mode == IDLE_BOTH) ? 9 : 0;
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_plain_letter <= letter;
        i_message_end  <= last;
        do @(posedge i_clk); while (!o_ready);
        letters_sent++;
    endtask

    // a whole message from uppercase text, end flag on the last letter
    task automatic send_text(string text);
        int i;
        for (i = 0; i < text.len(); i++) begin
            send_letter(t_letter'(text[i] - 8'd65), i == text.len() - 1);
        end
    endtask

    // random message: doubled letters are common, out-of-alphabet codes rare,
    // and an unclosed message just runs into the next one
    task automatic send_message(int len, logic closed);
        t_letter letter;
        t_letter prev;
        int      i;
        prev = '0;
        for (i = 0; i < len; i++) begin
            if (i > 0 && $urandom_range(99) < 20) begin
                letter = prev;
            end else if ($urandom_range(99) < 4) begin
                letter = t_letter'($urandom_range(31, 26));
            end else begin
                letter = t_letter'($urandom_range(25, 0));
            end
            prev = letter;
            send_letter(letter, closed && (i == len - 1));
        end
    endtask

    // hold the sender until every expected cipher item has come out
    task automatic drain_cipher(int settle);
        i_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    function automatic t_square text_square(string text);
        t_square sq;
        int      i;
        sq = '0;
        for (i = 0; i < SIDE*SIDE; i++) begin
            sq[i / SIDE][(i % SIDE)*LETTER_W +: LETTER_W] = t_letter'(text[i] - 8'd65);
        end
        return sq;
    endfunction

    // proper key square: the 25 letters without j in random order
    function automatic t_square shuffled_square();
        t_letter pool [SIDE*SIDE];
        t_letter tmp;
        t_square sq;
        int      i, j, k;
        k = 0;
        for (i = 0; i < 26; i++) begin
            if (t_letter'(i) != LETTER_J) begin
                pool[k] = t_letter'(i);
                k++;
            end
        end
        for (i = SIDE*SIDE - 1; i > 0; i--) begin
            j       = $urandom_range(i, 0);
            tmp     = pool[i];
            pool[i] = pool[j];
            pool[j] = tmp;
        end
        for (i = 0; i < SIDE*SIDE; i++) begin
            sq[i / SIDE][(i % SIDE)*LETTER_W +: LETTER_W] = pool[i];
        end
        return sq;
    endfunction

    // arbitrary row bits: duplicates, gaps and codes above z
    function automatic t_square noise_square();
        t_square sq;
        int      r;
        for (r = 0; r < SIDE; r++) begin
            sq[r] = t_row'($urandom);
        end
        return sq;
    endfunction

    initial begin : stimulus
        int      phase;
        int      start;
        int      len;
        bit      paused;
        t_square sq;

        tracker = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part on the textbook keyword square
        write_square(text_square("PLAYFIREXMBCDGHKNOQSTUVWZ"));
        send_text("HIDE");  // a rectangle pair and a same-column pair
        send_text("TREES"); // doubled e becomes x, odd tail padded with x
        send_text("IJ");    // j after i is kept, both land on the i cell
        send_text("A");     // single-letter message padded
        send_text("AAA");   // new message starts fresh; a, x, a
        send_text("XX");    // doubled x stays x, same cell
        send_text("YF");    // same row wrapping to column 0
        send_text("FZ");    // same column wrapping to row 0
        send_text("KQ");    // same row
        send_letter(t_letter'(31), 1'b0); // codes missing from the square
        send_letter(t_letter'(26), 1'b1);

        for (phase = 0; phase < PHASES; phase++) begin
            drain_cipher(SETTLE_CYCLES);
            idle_mode = t_idle_mode'(phase % 4);
            case (phase)
                1:       sq = '0;
                3:       sq = '1;
                4, 6:    sq = noise_square();
                default: sq = shuffled_square();
            endcase
            write_square(sq);
            start  = letters_sent;
            paused = 1'b0;
            while (letters_sent - start < PHASE_LETTERS) begin
                if (!paused && letters_sent - start >= PHASE_LETTERS / 2) begin
                    drain_cipher(0);
                    paused = 1'b1;
                end
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(8, 1);
                send_message(len, $urandom_range(9) != 0);
            end
        end

        drain_cipher(SETTLE_CYCLES);
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/pfe_pkg.sv
hdl/pfe_front.sv
hdl/pfe_encode.sv
hdl/pfe_out.sv
hdl/playfair_digraph_encrypt.sv
hdl/pfe_checker.sv
dv/cipher_tracker_pkg.sv
dv/tb_top.sv
